>>> rtl/bfc_pkg.sv
// ----------------------------------------------------------------------------
// bfc_pkg
// Shared types and constants of the best-fit block cache: entry geometry,
// result status codes and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package bfc_pkg;

  // Entry geometry
  localparam int unsigned CacheDepth = 8;
  localparam int unsigned IdxW       = $clog2(CacheDepth);
  localparam int unsigned CntW       = 4;
  localparam int unsigned SizeW      = 48;
  localparam int unsigned HandleW    = 64;

  // Operation codes
  localparam logic OpAlloc  = 1'b0;
  localparam logic OpReturn = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    StHit    = 3'd0,
    StMiss   = 3'd1,
    StStored = 3'd2,
    StEvict  = 3'd3,
    StNull   = 3'd4
  } status_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture request, restart scan
    logic step;    // advance scan index
    logic commit;  // update entries and result registers
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic stop;    // scan has reached its position
  } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/bfc_ctrl.sv
// ----------------------------------------------------------------------------
// bfc_ctrl
// Controller: accepts a request, steps the datapath scan until the position
// is found, commits the update and strobes the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_ctrl
  import bfc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o,
  output logic         busy_o,
  output logic         done_o
);

  typedef enum logic [1:0] {
    Idle,
    Scan,
    Commit
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;
  logic   accept;

  assign accept = start_i && !busy_q;

  // Commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == Idle) && accept;
    cmd_o.step   = (state_q == Scan) && !sts_i.stop;
    cmd_o.commit = (state_q == Commit);
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      // strobe follows the commit cycle
      done_q <= (state_q == Commit);
      unique case (state_q)
        Idle: begin
          if (accept) begin
            state_q <= Scan;
            busy_q  <= 1'b1;
          end
        end
        Scan: begin
          if (sts_i.stop) begin
            state_q <= Commit;
          end
        end
        Commit: begin
          state_q <= Idle;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= Idle;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

>>> rtl/bfc_dp.sv
// ----------------------------------------------------------------------------
// bfc_dp
// Datapath: sorted entry registers, the request registers, a one-compare-per-
// cycle scan and the shift/insert/remove update with the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bfc_dp
  import bfc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dp_cmd_t            cmd_i,
  output dp_sts_t                 sts_o,
  input  wire logic               op_i,
  input  wire logic [SizeW-1:0]   block_size_i,
  input  wire logic [HandleW-1:0] block_handle_i,
  output logic [2:0]              status_o,
  output logic [HandleW-1:0]      hit_handle_o,
  output logic [SizeW-1:0]        hit_size_o,
  output logic [HandleW-1:0]      evicted_handle_o,
  output logic [SizeW-1:0]        evicted_size_o,
  output logic [CntW-1:0]         cached_count_o
);

  // Entries, sorted by ascending size
  logic [SizeW-1:0]   size_q   [CacheDepth];
  logic [HandleW-1:0] handle_q [CacheDepth];
  logic [CntW-1:0]    cnt_q;

  // Captured request
  logic               op_q;
  logic [SizeW-1:0]   req_size_q;
  logic [HandleW-1:0] req_handle_q;
  logic [CntW-1:0]    idx_q;

  // Result registers
  status_e            status_q;
  logic [HandleW-1:0] hit_handle_q;
  logic [SizeW-1:0]   hit_size_q;
  logic [HandleW-1:0] ev_handle_q;
  logic [SizeW-1:0]   ev_size_q;

  // Neighbor views for shifting
  logic [SizeW-1:0]   size_up   [CacheDepth];
  logic [HandleW-1:0] handle_up [CacheDepth];
  logic [SizeW-1:0]   size_dn   [CacheDepth];
  logic [HandleW-1:0] handle_dn [CacheDepth];

  logic [SizeW-1:0]   rd_size;
  logic [HandleW-1:0] rd_handle;
  logic               scan_end;
  logic               is_null;
  logic               cmp_stop;
  logic               found;
  logic               full;
  logic               do_remove;
  logic               do_insert;

  for (genvar j = 0; j < CacheDepth; j++) begin : g_nbr
    if (j == CacheDepth - 1) begin : g_top
      assign size_up[j]   = size_q[j];
      assign handle_up[j] = handle_q[j];
    end else begin : g_mid
      assign size_up[j]   = size_q[j+1];
      assign handle_up[j] = handle_q[j+1];
    end
    if (j == 0) begin : g_bot
      assign size_dn[j]   = size_q[j];
      assign handle_dn[j] = handle_q[j];
    end else begin : g_low
      assign size_dn[j]   = size_q[j-1];
      assign handle_dn[j] = handle_q[j-1];
    end
  end

  // Scan read port and stop condition
  assign rd_size   = size_q[idx_q[IdxW-1:0]];
  assign rd_handle = handle_q[idx_q[IdxW-1:0]];
  assign scan_end  = (idx_q == cnt_q);
  assign is_null   = (op_q == OpReturn) && (req_handle_q == '0);
  // allocation stops at the first fit; return stops past equal sizes
  assign cmp_stop  = (op_q == OpReturn) ? (rd_size > req_size_q)
                                        : (rd_size >= req_size_q);
  assign sts_o.stop = scan_end || is_null || cmp_stop;

  // Update decode
  assign found     = !scan_end;
  assign full      = (cnt_q == CntW'(CacheDepth));
  assign do_remove = (op_q == OpAlloc) && found;
  assign do_insert = (op_q == OpReturn) && !is_null && !(full && scan_end);

  // Request capture and scan index
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q         <= op_i;
      req_size_q   <= block_size_i;
      req_handle_q <= block_handle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + CntW'(1);
    end
  end

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.commit) begin
      if (do_remove) begin
        cnt_q <= cnt_q - CntW'(1);
      end else if (do_insert && !full) begin
        cnt_q <= cnt_q + CntW'(1);
      end
    end
  end

  // Entry shift, insert and remove
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      for (int unsigned j = 0; j < CacheDepth; j++) begin
        if (do_remove && (CntW'(j) >= idx_q)) begin
          size_q[j]   <= size_up[j];
          handle_q[j] <= handle_up[j];
        end else if (do_insert && (CntW'(j) > idx_q)) begin
          size_q[j]   <= size_dn[j];
          handle_q[j] <= handle_dn[j];
        end else if (do_insert && (CntW'(j) == idx_q)) begin
          size_q[j]   <= req_size_q;
          handle_q[j] <= req_handle_q;
        end
      end
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (op_q == OpAlloc) begin
        ev_handle_q <= '0;
        ev_size_q   <= '0;
        if (found) begin
          status_q     <= StHit;
          hit_handle_q <= rd_handle;
          hit_size_q   <= rd_size;
        end else begin
          status_q     <= StMiss;
          hit_handle_q <= '0;
          hit_size_q   <= '0;
        end
      end else begin
        hit_handle_q <= '0;
        hit_size_q   <= '0;
        if (is_null) begin
          status_q    <= StNull;
          ev_handle_q <= '0;
          ev_size_q   <= '0;
        end else if (full) begin
          status_q <= StEvict;
          if (scan_end) begin
            // new block is the largest: evicted at once
            ev_handle_q <= req_handle_q;
            ev_size_q   <= req_size_q;
          end else begin
            ev_handle_q <= handle_q[CacheDepth-1];
            ev_size_q   <= size_q[CacheDepth-1];
          end
        end else begin
          status_q    <= StStored;
          ev_handle_q <= '0;
          ev_size_q   <= '0;
        end
      end
    end
  end

  assign status_o         = status_q;
  assign hit_handle_o     = hit_handle_q;
  assign hit_size_o       = hit_size_q;
  assign evicted_handle_o = ev_handle_q;
  assign evicted_size_o   = ev_size_q;
  assign cached_count_o   = cnt_q;

endmodule

`default_nettype wire

>>> rtl/best_fit_block_cache.sv
// ----------------------------------------------------------------------------
// best_fit_block_cache
// Best-fit cache of freed blocks: allocation requests take the smallest
// cached block that fits, returns are inserted in size order with eviction
// of the largest entry on overflow.
// ----------------------------------------------------------------------------
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------
//  request   | start / busy          | op_i, block_size_i, block_handle_i
//  result    | done_o (1-cycle pulse)| status_o, hit_*_o, evicted_*_o,
//            |                       | cached_count_o
//
//  A request is taken when start is high and busy is low. The scan compares
//  one entry per cycle and passes 0 to 8 entries, then the Commit state updates
//  the entries and the strobe is registered from it. A null return stops the scan
//  at once. One request is in flight at a time; busy drops in the strobe cycle,
//  so the next request may be taken there. Reset empties the cache; no clearing
//  pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_block_cache
  import bfc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               op_i,
  input  wire logic [SizeW-1:0]   block_size_i,
  input  wire logic [HandleW-1:0] block_handle_i,
  output logic                    done_o,
  output logic [2:0]              status_o,
  output logic [HandleW-1:0]      hit_handle_o,
  output logic [SizeW-1:0]        hit_size_o,
  output logic [HandleW-1:0]      evicted_handle_o,
  output logic [SizeW-1:0]        evicted_size_o,
  output logic [CntW-1:0]         cached_count_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bfc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  bfc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_i),
    .block_size_i    (block_size_i),
    .block_handle_i  (block_handle_i),
    .status_o        (status_o),
    .hit_handle_o    (hit_handle_o),
    .hit_size_o      (hit_size_o),
    .evicted_handle_o(evicted_handle_o),
    .evicted_size_o  (evicted_size_o),
    .cached_count_o  (cached_count_o)
  );

  // Result strobe only after the request has finished
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Count never exceeds the capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cached_count_o <= CntW'(CacheDepth))
    else $error("entry count above capacity");

  // A cached block never carries the null handle
  a_hit_nonnull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StHit) |-> (hit_handle_o != '0))
    else $error("hit with null handle");

  a_evict_nonnull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == StEvict) |-> (evicted_handle_o != '0))
    else $error("eviction with null handle");

  // A taken request makes the block busy
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken without going busy");

endmodule

`default_nettype wire

>>> tb/sv/best_fit_block_cache_test.sv
// ----------------------------------------------------------------------------
// best_fit_block_cache_test
// Self-checking bench for the best-fit block cache. A queue-fed driver issues
// allocation and return requests through the start/busy handshake. A software
// image of the sorted cache predicts each response. A monitor checks every
// done_o strobe field by field against the oldest prediction. The run is a
// directed corner pass followed by phased random traffic that fills and
// drains the cache, with random sender gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_block_cache_test;
  import bfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomRequests = 1150;
  localparam int QuietTail      = 150;
  localparam int CycleLimit     = 200000;
  localparam int SettleCycles   = 16;

  // One request waiting to be driven
  typedef struct {
    logic               op;
    logic [SizeW-1:0]   blk_size;
    logic [HandleW-1:0] handle;
    int                 gap;    // idle cycles before this request
    bit                 drain;  // hold off until all responses are back
  } request_t;

  // Predicted response
  typedef struct packed {
    status_e            status;
    logic [HandleW-1:0] hit_handle;
    logic [SizeW-1:0]   hit_size;
    logic [HandleW-1:0] evicted_handle;
    logic [SizeW-1:0]   evicted_size;
    logic [CntW-1:0]    count;
  } outcome_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               op_i;
  logic [SizeW-1:0]   block_size_i;
  logic [HandleW-1:0] block_handle_i;
  logic               done_o;
  logic [2:0]         status_o;
  logic [HandleW-1:0] hit_handle_o;
  logic [SizeW-1:0]   hit_size_o;
  logic [HandleW-1:0] evicted_handle_o;
  logic [SizeW-1:0]   evicted_size_o;
  logic [CntW-1:0]    cached_count_o;

  request_t pending_q[$];
  outcome_t expected_q[$];

  // Software image of the cache contents, kept sorted by size
  logic [SizeW-1:0]   held_sizes   [CacheDepth];
  logic [HandleW-1:0] held_handles [CacheDepth];
  int                 held_count = 0;

  int n_sent = 0;
  int n_recv = 0;
  int gap_left = 0;
  int mismatches = 0;
  int n_hit = 0, n_miss = 0, n_stored = 0, n_evict = 0, n_null = 0;
  int cycle_count = 0;

  best_fit_block_cache dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .op_i             (op_i),
    .block_size_i     (block_size_i),
    .block_handle_i   (block_handle_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .hit_handle_o     (hit_handle_o),
    .hit_size_o       (hit_size_o),
    .evicted_handle_o (evicted_handle_o),
    .evicted_size_o   (evicted_size_o),
    .cached_count_o   (cached_count_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the cache image and return the response it yields
  function automatic outcome_t predict_outcome(input logic op,
                                               input logic [SizeW-1:0] req_size,
                                               input logic [HandleW-1:0] handle);
    outcome_t r;
    int       slot;
    int       pos;
    int       i;
    r = '0;
    if (op == OpAlloc) begin
      // first entry that fits is the best fit, earliest among equal sizes
      slot = -1;
      for (i = 0; i < held_count; i++)
        if (slot < 0 && held_sizes[i] >= req_size) slot = i;
      if (slot < 0) begin
        r.status = StMiss;
      end else begin
        r.status     = StHit;
        r.hit_handle = held_handles[slot];
        r.hit_size   = held_sizes[slot];
        for (i = slot; i < held_count - 1; i++) begin
          held_sizes[i]   = held_sizes[i+1];
          held_handles[i] = held_handles[i+1];
        end
        held_count--;
      end
    end else if (handle == '0) begin
      r.status = StNull;
    end else begin
      // insert after every entry of equal or smaller size
      pos = 0;
      while (pos < held_count && held_sizes[pos] <= req_size) pos++;
      if (held_count >= CacheDepth) begin
        r.status = StEvict;
        if (pos >= CacheDepth) begin
          r.evicted_handle = handle;
          r.evicted_size   = req_size;
        end else begin
          r.evicted_handle = held_handles[CacheDepth-1];
          r.evicted_size   = held_sizes[CacheDepth-1];
          for (i = CacheDepth - 1; i > pos; i--) begin
            held_sizes[i]   = held_sizes[i-1];
            held_handles[i] = held_handles[i-1];
          end
          held_sizes[pos]   = req_size;
          held_handles[pos] = handle;
        end
      end else begin
        r.status = StStored;
        for (i = held_count; i > pos; i--) begin
          held_sizes[i]   = held_sizes[i-1];
          held_handles[i] = held_handles[i-1];
        end
        held_sizes[pos]   = req_size;
        held_handles[pos] = handle;
        held_count++;
      end
    end
    r.count = held_count[CntW-1:0];
    return r;
  endfunction

  function automatic void add_request(input logic op, input logic [SizeW-1:0] sz,
                                      input logic [HandleW-1:0] h,
                                      input int gap = 0, input bit drain = 1'b0);
    request_t q;
    q.op       = op;
    q.blk_size = sz;
    q.handle   = h;
    q.gap      = gap;
    q.drain    = drain;
    pending_q.push_back(q);
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Driver: predicts on acceptance, then holds, idles or issues the next request
  always @(posedge clk_i) begin
    bit   take;
    logic nxt_start;
    if (rst_ni) begin
      take      = start && !busy;
      nxt_start = start;
      if (take) begin
        expected_q.push_back(predict_outcome(op_i, block_size_i, block_handle_i));
        n_sent <= n_sent + 1;
      end
      if (!start || take) begin
        nxt_start = 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_q.size() > 0) begin
          if (pending_q[0].gap > 0) begin
            gap_left <= pending_q[0].gap - 1;
            pending_q[0].gap = 0;
          end else if (!(pending_q[0].drain && (take || n_sent != n_recv))) begin
            op_i           <= pending_q[0].op;
            block_size_i   <= pending_q[0].blk_size;
            block_handle_i <= pending_q[0].handle;
            void'(pending_q.pop_front());
            nxt_start = 1'b1;
          end
        end
      end
      start <= nxt_start;
    end
  end

  // Monitor: every strobe must match the oldest prediction
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $error("response with no request outstanding: status %0d", status_o);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        compare_field("status", 64'(want.status), 64'(status_o));
        compare_field("hit_handle", want.hit_handle, hit_handle_o);
        compare_field("hit_size", 64'(want.hit_size), 64'(hit_size_o));
        compare_field("evicted_handle", want.evicted_handle, evicted_handle_o);
        compare_field("evicted_size", 64'(want.evicted_size), 64'(evicted_size_o));
        compare_field("cached_count", 64'(want.count), 64'(cached_count_o));
        case (want.status)
          StHit:    n_hit++;
          StMiss:   n_miss++;
          StStored: n_stored++;
          StEvict:  n_evict++;
          default:  n_null++;
        endcase
      end
      n_recv <= n_recv + 1;
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[best_fit_block_cache] ERROR");
    $finish;
  end

  // Stimulus and end of test
  initial begin
    logic [SizeW-1:0]   max_size;
    logic [HandleW-1:0] max_handle;
    logic [SizeW-1:0]   sz;
    logic [HandleW-1:0] h;
    logic               op;
    int                 return_bias;
    bit                 idling;
    int                 gap;
    int                 n;

    rst_ni         = 1'b0;
    start          = 1'b0;
    op_i           = OpAlloc;
    block_size_i   = '0;
    block_handle_i = '0;
    max_size       = '1;
    max_handle     = '1;

    // Directed: empty-cache misses and null returns
    add_request(OpAlloc, '0, '0);
    add_request(OpAlloc, max_size, max_handle);
    add_request(OpReturn, 48'd5, '0);
    add_request(OpReturn, max_size, '0);
    // fill to capacity, with a tie, a zero size and the largest size
    add_request(OpReturn, 48'd100, 64'h1);
    add_request(OpReturn, 48'd100, 64'h2);
    add_request(OpReturn, '0, 64'h3);
    add_request(OpReturn, max_size, max_handle);
    add_request(OpReturn, 48'd50, 64'h5);
    add_request(OpReturn, 48'd200, 64'h6);
    add_request(OpReturn, 48'd300, 64'h7);
    add_request(OpReturn, 48'd400, 64'h8, 0, 1'b1);
    // full cache: a largest-size return evicts itself, a small one evicts the top
    add_request(OpReturn, max_size, 64'hA5A5_5A5A_0F0F_F0F0);
    add_request(OpReturn, 48'd1, 64'h9);
    add_request(OpReturn, 48'd100, 64'hA);
    // tie goes to the earliest, zero request takes the smallest
    add_request(OpAlloc, 48'd100, max_handle);
    add_request(OpAlloc, '0, '0);
    add_request(OpAlloc, 48'd401, '0);
    add_request(OpAlloc, max_size, '0);
    add_request(OpAlloc, 48'd100, '0);
    add_request(OpAlloc, 48'd100, '0);
    add_request(OpAlloc, 48'd1, '0);
    add_request(OpAlloc, 48'd1, '0);
    add_request(OpAlloc, 48'd1, '0);
    add_request(OpAlloc, '0, '0);

    // Random: phases leaning toward returns or allocations so occupancy sweeps
    return_bias = 75;
    idling      = 1'b0;
    for (n = 0; n < RandomRequests; n++) begin
      if (n % 40 == 0) return_bias = $urandom_range(0, 1) ? 75 : 30;
      if (n % 64 == 0) idling = ($urandom_range(0, 2) != 0);
      op = ($urandom_range(0, 99) < return_bias) ? OpReturn : OpAlloc;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: sz = SizeW'($urandom_range(0, 63));
        6, 7:             sz = SizeW'($urandom_range(0, 4095));
        8:                sz = $urandom_range(0, 1) ? max_size : '0;
        default:          sz = SizeW'({$urandom, $urandom});
      endcase
      h = ($urandom_range(0, 19) == 0) ? '0 : {$urandom, $urandom};
      gap = 0;
      if (idling && n < RandomRequests - QuietTail && $urandom_range(0, 2) == 0)
        gap = $urandom_range(1, 8);
      add_request(op, sz, h, gap, (n % 250 == 249));
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the last request to be taken and answered
    @(negedge clk_i);
    while (pending_q.size() > 0 || start || n_sent != n_recv || expected_q.size() > 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);

    if (expected_q.size() > 0) begin
      $error("%0d responses never arrived", expected_q.size());
      mismatches++;
    end
    $display("Checked %0d responses: %0d hits, %0d misses, %0d stored,", n_recv, n_hit,
             n_miss, n_stored);
    $display("  %0d evictions, %0d null returns; %0d mismatches", n_evict, n_null,
             mismatches);
    if (mismatches == 0) begin
      $display("[best_fit_block_cache] OK");
    end else begin
      $display("[best_fit_block_cache] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> best_fit_block_cache.f
rtl/bfc_pkg.sv
rtl/bfc_ctrl.sv
rtl/bfc_dp.sv
rtl/best_fit_block_cache.sv
tb/sv/best_fit_block_cache_test.sv
